/* src/fsap_pkg.sv */
// ----------------------------------------------------------------------------
// fsap_pkg: shared types and constants for the five-stage ALU pipeline
// Instruction and writeback beat types, operation codes, default sizes.
// ----------------------------------------------------------------------------
package fsap_pkg;

  // Default configuration
  localparam int REG_NUM_DEF   = 32;
  localparam int DATA_BITS_DEF = 32;

  // Fixed field widths of the beats
  localparam int MODE_W     = 4;
  localparam int REG_ADDR_W = 5;
  localparam int IMM_W      = 12;
  localparam int WB_VALUE_W = 32;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_ADDI    = 4'd2,
    OP_AND     = 4'd3,
    OP_OR      = 4'd4,
    OP_XOR     = 4'd5,
    OP_HALT    = 4'd6,
    OP_NOP     = 4'd7,
    OP_ILLEGAL = 4'd8
  } op_e;

  // One fetched instruction
  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [REG_ADDR_W-1:0] dest_reg;
    logic [REG_ADDR_W-1:0] src_a_reg;
    logic [REG_ADDR_W-1:0] src_b_reg;
    logic signed [IMM_W-1:0] immediate;
  } in_t;

  // One cycle of writeback status
  typedef struct packed {
    logic                    wb_valid;
    logic [REG_ADDR_W-1:0]   wb_reg;
    logic signed [WB_VALUE_W-1:0] wb_value;
    logic                    halted;
    logic                    fault;
  } out_t;

endpackage

/* src/fsap_regfile.sv */
// ----------------------------------------------------------------------------
// fsap_regfile: register file with decode-stage operand registers
// One write port, two registered read ports, write-first bypass, per-entry
// valid bits so that unwritten registers read as zero after reset.
// ----------------------------------------------------------------------------
module fsap_regfile #(
  parameter int REG_NUM   = fsap_pkg::REG_NUM_DEF,
  parameter int DATA_BITS = fsap_pkg::DATA_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [fsap_pkg::REG_ADDR_W-1:0] waddr_i,
  input  logic [DATA_BITS-1:0]            wdata_i,
  input  logic                            re_i,
  input  logic [fsap_pkg::REG_ADDR_W-1:0] raddr_a_i,
  input  logic [fsap_pkg::REG_ADDR_W-1:0] raddr_b_i,
  output logic [DATA_BITS-1:0]            rdata_a_o,
  output logic [DATA_BITS-1:0]            rdata_b_o
);
  import fsap_pkg::*;

  localparam int IDX_W = (REG_NUM > 1) ? $clog2(REG_NUM) : 1;
  localparam logic [REG_ADDR_W:0] REG_LIM = (REG_ADDR_W + 1)'(REG_NUM);

  logic [DATA_BITS-1:0] mem [REG_NUM];
  logic [REG_NUM-1:0]   vld_q;
  logic [DATA_BITS-1:0] rdata_a_q, rdata_b_q;

  logic [IDX_W-1:0] widx, aidx, bidx;
  logic             a_ok, b_ok, a_byp, b_byp;

  assign widx  = waddr_i[IDX_W-1:0];
  assign aidx  = raddr_a_i[IDX_W-1:0];
  assign bidx  = raddr_b_i[IDX_W-1:0];
  // x0 and out-of-range numbers read as zero
  assign a_ok  = (raddr_a_i != '0) && ({1'b0, raddr_a_i} < REG_LIM);
  assign b_ok  = (raddr_b_i != '0) && ({1'b0, raddr_b_i} < REG_LIM);
  // writeback lands before the decode read of the same cycle
  assign a_byp = we_i && (waddr_i == raddr_a_i);
  assign b_byp = we_i && (waddr_i == raddr_b_i);

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[widx] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rdata_a_q <= '0;
      rdata_b_q <= '0;
    end else begin
      if (we_i) begin
        vld_q[widx] <= 1'b1;
      end
      if (re_i) begin
        if (a_byp) begin
          rdata_a_q <= wdata_i;
        end else if (a_ok && vld_q[aidx]) begin
          rdata_a_q <= mem[aidx];
        end else begin
          rdata_a_q <= '0;
        end
        if (b_byp) begin
          rdata_b_q <= wdata_i;
        end else if (b_ok && vld_q[bidx]) begin
          rdata_b_q <= mem[bidx];
        end else begin
          rdata_b_q <= '0;
        end
      end
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* src/fsap_alu.sv */
// ----------------------------------------------------------------------------
// fsap_alu: execute stage operand forwarding and ALU
// EX/MEM result has priority over MEM/WB; arithmetic wraps at DATA_BITS.
// ----------------------------------------------------------------------------
module fsap_alu #(
  parameter int DATA_BITS = fsap_pkg::DATA_BITS_DEF
) (
  input  fsap_pkg::in_t                   instr_i,
  input  logic [DATA_BITS-1:0]            op_a_i,
  input  logic [DATA_BITS-1:0]            op_b_i,
  input  logic                            ex_fwd_i,
  input  logic [fsap_pkg::REG_ADDR_W-1:0] ex_dest_i,
  input  logic [DATA_BITS-1:0]            ex_result_i,
  input  logic                            mem_fwd_i,
  input  logic [fsap_pkg::REG_ADDR_W-1:0] mem_dest_i,
  input  logic [DATA_BITS-1:0]            mem_result_i,
  output logic [DATA_BITS-1:0]            result_o
);
  import fsap_pkg::*;

  logic [DATA_BITS-1:0] a, b, imm_ext;

  assign imm_ext = DATA_BITS'($signed(instr_i.immediate));

  always_comb begin
    if (ex_fwd_i && (ex_dest_i == instr_i.src_a_reg)) begin
      a = ex_result_i;
    end else if (mem_fwd_i && (mem_dest_i == instr_i.src_a_reg)) begin
      a = mem_result_i;
    end else begin
      a = op_a_i;
    end
    if (ex_fwd_i && (ex_dest_i == instr_i.src_b_reg)) begin
      b = ex_result_i;
    end else if (mem_fwd_i && (mem_dest_i == instr_i.src_b_reg)) begin
      b = mem_result_i;
    end else begin
      b = op_b_i;
    end
  end

  always_comb begin
    unique case (instr_i.mode)
      OP_ADD:  result_o = a + b;
      OP_SUB:  result_o = a - b;
      OP_ADDI: result_o = a + imm_ext;
      OP_AND:  result_o = a & b;
      OP_OR:   result_o = a | b;
      OP_XOR:  result_o = a ^ b;
      default: result_o = '0;
    endcase
  end

endmodule

/* src/fsap_out_buf.sv */
// ----------------------------------------------------------------------------
// fsap_out_buf: two-entry output buffer
// Output register plus skid entry; upstream stalls only when the skid is full.
// ----------------------------------------------------------------------------
module fsap_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fsap_pkg::out_t push_data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fsap_pkg::out_t out_data_o
);
  import fsap_pkg::*;

  out_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic load_main;

  // main register is free when empty or its beat leaves this cycle
  assign load_main = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load_main) begin
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_main) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/five_stage_alu_pipeline.sv */
// ----------------------------------------------------------------------------
// five_stage_alu_pipeline: fetch/decode/execute/memory/writeback ALU pipeline
// Each accepted instruction beat yields a status beat, registered in the output buffer.
// Throughput: one instruction per cycle; in_stall_o rises only when both the
// output register and the skid entry hold beats.
// Reset: async, active low; pipeline, flags and register file read as zero.
// ----------------------------------------------------------------------------
module five_stage_alu_pipeline #(
  parameter int REG_NUM   = fsap_pkg::REG_NUM_DEF,
  parameter int DATA_BITS = fsap_pkg::DATA_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fsap_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fsap_pkg::out_t out_data_o
);
  import fsap_pkg::*;

  localparam logic [REG_ADDR_W:0] REG_LIM = (REG_ADDR_W + 1)'(REG_NUM);

  // Each accepted beat is one clock of the modeled pipeline. All stage work
  // happens in the cycle of acceptance, between the stage registers below,
  // and the status beat is captured into the output buffer.

  // Pipeline state
  in_t                   fetch_q;            // IF/ID
  in_t                   dec_q;              // ID/EX instruction
  logic                  dec_wen_q;
  logic [DATA_BITS-1:0]  ex_result_q;        // EX/MEM
  logic [REG_ADDR_W-1:0] ex_dest_q;
  logic                  ex_wen_q;
  logic                  ex_halt_q;
  logic [DATA_BITS-1:0]  mem_result_q;       // MEM/WB
  logic [REG_ADDR_W-1:0] mem_dest_q;
  logic                  mem_wen_q;
  logic                  mem_halt_q;
  logic                  halted_q;
  logic                  fault_q;

  logic                  accept, active, step;
  logic                  ex_fwd, mem_fwd, wb_we, illegal;
  logic                  halt_now, fault_now;
  logic [DATA_BITS-1:0]  op_a, op_b, alu_res;
  in_t                   dec_d;
  out_t                  status;

  // A write is real only for a nonzero register below REG_NUM
  function automatic logic writes(input logic en, input logic [REG_ADDR_W-1:0] r);
    writes = en && (r != '0) && ({1'b0, r} < REG_LIM);
  endfunction

  assign accept  = in_valid_i && !in_stall_o;
  assign active  = !halted_q && !fault_q;   // once stopped, beats are ignored
  assign step    = accept && active;

  assign ex_fwd  = writes(ex_wen_q, ex_dest_q);
  assign mem_fwd = writes(mem_wen_q, mem_dest_q);
  assign wb_we   = step && mem_fwd;

  // mode codes 8..15 are all illegal
  assign illegal   = (fetch_q.mode >= OP_ILLEGAL);
  assign halt_now  = halted_q || (active && mem_halt_q);
  assign fault_now = fault_q || (active && illegal);

  // Register file: WB write port, ID read ports (registered operands)
  fsap_regfile #(
    .REG_NUM   (REG_NUM),
    .DATA_BITS (DATA_BITS)
  ) u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (wb_we),
    .waddr_i   (mem_dest_q),
    .wdata_i   (mem_result_q),
    .re_i      (step && !illegal),
    .raddr_a_i (fetch_q.src_a_reg),
    .raddr_b_i (fetch_q.src_b_reg),
    .rdata_a_o (op_a),
    .rdata_b_o (op_b)
  );

  // Execute with forwarding from EX/MEM, then MEM/WB
  fsap_alu #(
    .DATA_BITS (DATA_BITS)
  ) u_alu (
    .instr_i      (dec_q),
    .op_a_i       (op_a),
    .op_b_i       (op_b),
    .ex_fwd_i     (ex_fwd),
    .ex_dest_i    (ex_dest_q),
    .ex_result_i  (ex_result_q),
    .mem_fwd_i    (mem_fwd),
    .mem_dest_i   (mem_dest_q),
    .mem_result_i (mem_result_q),
    .result_o     (alu_res)
  );

  // Decode: an illegal instruction turns into a nop bubble
  always_comb begin
    dec_d = fetch_q;
    if (illegal) begin
      dec_d.mode = OP_NOP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_q      <= '0;
      dec_q        <= '0;
      dec_wen_q    <= 1'b0;
      ex_result_q  <= '0;
      ex_dest_q    <= '0;
      ex_wen_q     <= 1'b0;
      ex_halt_q    <= 1'b0;
      mem_result_q <= '0;
      mem_dest_q   <= '0;
      mem_wen_q    <= 1'b0;
      mem_halt_q   <= 1'b0;
      halted_q     <= 1'b0;
      fault_q      <= 1'b0;
    end else if (step) begin
      // MEM passes EX/MEM on to MEM/WB
      mem_result_q <= ex_result_q;
      mem_dest_q   <= ex_dest_q;
      mem_wen_q    <= ex_wen_q;
      mem_halt_q   <= ex_halt_q;
      // EX
      ex_result_q  <= alu_res;
      ex_dest_q    <= dec_q.dest_reg;
      ex_wen_q     <= dec_wen_q;
      ex_halt_q    <= (dec_q.mode == OP_HALT);
      // ID
      dec_q        <= dec_d;
      dec_wen_q    <= !illegal && (fetch_q.mode != OP_HALT) && (fetch_q.mode != OP_NOP);
      // IF: nothing new enters once the block stops
      if (!mem_halt_q && !illegal) begin
        fetch_q    <= in_data_i;
      end
      halted_q     <= halt_now;
      fault_q      <= fault_now;
    end
  end

  // Status beat for this cycle
  always_comb begin
    status          = '0;
    status.wb_valid = active && mem_fwd;
    if (active && mem_fwd) begin
      status.wb_reg   = mem_dest_q;
      status.wb_value = WB_VALUE_W'(mem_result_q);
    end
    status.halted   = halt_now;
    status.fault    = fault_now;
  end

  fsap_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (status),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Assertions
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |=> fault_q)
    else $error("fault flag cleared");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted flag cleared");

  a_no_write_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halted_q || fault_q) |-> !wb_we)
    else $error("register write after stop");

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_we |-> (mem_dest_q != '0))
    else $error("write to register zero");

endmodule
